>>> sv/bog_pkg.sv
package bog_pkg;

    // Default sizing handed to the top level
    localparam int MAX_RANK_DEF   = 4;
    localparam int DIM_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 32;

    // Register port geometry: four 64-bit registers at 8-byte spacing
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_ADDR_W = CFG_IDX_W + 3;
    localparam int RANK_W     = 3;
    localparam int ORANK_W    = 4;

    localparam logic [CFG_DATA_W-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;
    localparam logic [RANK_W-1:0]     RANK_RESET = 3'd1;

    // Small word queues between the parts
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_DIMS,
        REG_RIGHT_DIMS,
        REG_LEFT_RANK,
        REG_RIGHT_RANK
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_EXHAUSTED,
        CMD_RESTART,
        CMD_ADVANCE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic      last;
    } t_cmd_ctl;

    typedef struct packed {
        logic busy;
        logic ok;
    } t_shape_status;

    typedef struct packed {
        logic last;
        logic exhausted;
        logic shape_error;
    } t_out_flags;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM
    } t_back_state;

endpackage

>>> sv/bog_fifo.sv
module bog_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import bog_pkg::*;

    logic [WIDTH-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_push_ok;
    logic                  w_pop_ok;

    assign o_full    = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rptr];

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push_ok) begin
                r_wptr <= (r_wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rptr <= (r_rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/bog_cfg.sv
module bog_cfg #(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [bog_pkg::CFG_ADDR_W-1:0]  i_paddr,
    input  logic [bog_pkg::CFG_DATA_W-1:0]  i_pwdata,
    output logic [bog_pkg::CFG_DATA_W-1:0]  o_prdata,
    output logic                            o_pready,
    output bog_pkg::t_shape_status          o_status,
    output logic [INDEX_BITS-1:0]           o_total_m1,
    output logic [bog_pkg::ORANK_W-1:0]     o_orank,
    output logic [DIM_BITS-1:0]             o_out_dims [MAX_RANK],
    output logic                            o_left_unit [MAX_RANK],
    output logic                            o_right_unit [MAX_RANK],
    output logic [INDEX_BITS-1:0]           o_left_stride [MAX_RANK],
    output logic [INDEX_BITS-1:0]           o_right_stride [MAX_RANK]
);
    import bog_pkg::*;

    localparam int AXIS_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int PW     = INDEX_BITS + DIM_BITS;
    localparam logic [ORANK_W-1:0] MaxRank = ORANK_W'(MAX_RANK);
    localparam logic [DIM_BITS-1:0] DimOne = DIM_BITS'(1);

    logic [CFG_DATA_W-1:0] r_left_dims;
    logic [CFG_DATA_W-1:0] r_right_dims;
    logic [RANK_W-1:0]     r_left_rank;
    logic [RANK_W-1:0]     r_right_rank;

    logic                  r_busy;
    logic [AXIS_W-1:0]     r_axis;
    logic                  r_ok;
    logic [INDEX_BITS-1:0] r_total;
    logic [INDEX_BITS-1:0] r_lstr;
    logic [INDEX_BITS-1:0] r_rstr;
    logic [DIM_BITS-1:0]   r_od [MAX_RANK];
    logic                  r_lunit [MAX_RANK];
    logic                  r_runit [MAX_RANK];
    logic [INDEX_BITS-1:0] r_lstride [MAX_RANK];
    logic [INDEX_BITS-1:0] r_rstride [MAX_RANK];

    logic                  w_write;
    t_reg_idx              w_idx;
    logic [ORANK_W-1:0]    w_lrank;
    logic [ORANK_W-1:0]    w_rrank;
    logic [DIM_BITS-1:0]   w_lfield [MAX_RANK];
    logic [DIM_BITS-1:0]   w_rfield [MAX_RANK];
    logic [DIM_BITS-1:0]   w_ld;
    logic [DIM_BITS-1:0]   w_rd;
    logic [DIM_BITS-1:0]   w_od;
    logic                  w_dim_err;
    logic [PW-1:0]         w_prod;
    logic [PW-1:0]         w_lnext;
    logic [PW-1:0]         w_rnext;
    logic                  w_ovf;

    assign o_pready = 1'b1;
    assign w_write  = i_psel && i_penable && i_pwrite;
    assign w_idx    = t_reg_idx'(i_paddr[CFG_ADDR_W-1:3]);

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_LEFT_DIMS:  o_prdata = r_left_dims;
            REG_RIGHT_DIMS: o_prdata = r_right_dims;
            REG_LEFT_RANK:  o_prdata = CFG_DATA_W'(r_left_rank);
            REG_RIGHT_RANK: o_prdata = CFG_DATA_W'(r_right_rank);
            default:        o_prdata = '0;
        endcase
    end

    // Clamp ranks and unpack the dimension fields
    always_comb begin
        w_lrank = ({1'b0, r_left_rank} > MaxRank) ? MaxRank : {1'b0, r_left_rank};
        w_rrank = ({1'b0, r_right_rank} > MaxRank) ? MaxRank : {1'b0, r_right_rank};
        for (int a = 0; a < MAX_RANK; a++) begin
            w_lfield[a] = DIM_BITS'(r_left_dims >> (a * DIM_BITS));
            w_rfield[a] = DIM_BITS'(r_right_dims >> (a * DIM_BITS));
        end
    end

    assign o_orank = (w_lrank > w_rrank) ? w_lrank : w_rrank;

    // Check one axis per cycle: broadcast rule, element count, strides
    always_comb begin
        w_ld      = (ORANK_W'(r_axis) < w_lrank) ? w_lfield[r_axis] : DimOne;
        w_rd      = (ORANK_W'(r_axis) < w_rrank) ? w_rfield[r_axis] : DimOne;
        w_od      = (w_ld > w_rd) ? w_ld : w_rd;
        w_dim_err = (w_ld == '0) || (w_rd == '0)
                    || ((w_ld != w_rd) && (w_ld != DimOne) && (w_rd != DimOne));
        w_prod    = PW'(r_total) * PW'(w_od);
        w_lnext   = PW'(r_lstr) * PW'(w_ld);
        w_rnext   = PW'(r_rstr) * PW'(w_rd);
        w_ovf     = (w_prod[PW-1:INDEX_BITS] != '0);
    end

    // Hold the registers and run the shape check after reset or any write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dims  <= DIMS_RESET;
            r_right_dims <= DIMS_RESET;
            r_left_rank  <= RANK_RESET;
            r_right_rank <= RANK_RESET;
            r_busy       <= 1'b1;
            r_axis       <= '0;
            r_ok         <= 1'b1;
            r_total      <= INDEX_BITS'(1);
            r_lstr       <= INDEX_BITS'(1);
            r_rstr       <= INDEX_BITS'(1);
        end else if (w_write) begin
            unique case (w_idx)
                REG_LEFT_DIMS:  r_left_dims  <= i_pwdata;
                REG_RIGHT_DIMS: r_right_dims <= i_pwdata;
                REG_LEFT_RANK:  r_left_rank  <= i_pwdata[RANK_W-1:0];
                REG_RIGHT_RANK: r_right_rank <= i_pwdata[RANK_W-1:0];
                default: ;
            endcase
            r_busy  <= 1'b1;
            r_axis  <= '0;
            r_ok    <= 1'b1;
            r_total <= INDEX_BITS'(1);
            r_lstr  <= INDEX_BITS'(1);
            r_rstr  <= INDEX_BITS'(1);
        end else if (r_busy) begin
            r_ok    <= r_ok && !w_dim_err && !w_ovf;
            r_total <= w_prod[INDEX_BITS-1:0];
            r_lstr  <= w_lnext[INDEX_BITS-1:0];
            r_rstr  <= w_rnext[INDEX_BITS-1:0];
            if (r_axis == AXIS_W'(MAX_RANK - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_axis <= r_axis + 1'b1;
            end
        end
    end

    // Record per-axis results of the check
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_od[r_axis]      <= w_od;
            r_lunit[r_axis]   <= (w_ld == DimOne);
            r_runit[r_axis]   <= (w_rd == DimOne);
            r_lstride[r_axis] <= r_lstr;
            r_rstride[r_axis] <= r_rstr;
        end
    end

    assign o_status.busy  = r_busy;
    assign o_status.ok    = r_ok;
    assign o_total_m1     = r_total - 1'b1;
    assign o_out_dims     = r_od;
    assign o_left_unit    = r_lunit;
    assign o_right_unit   = r_runit;
    assign o_left_stride  = r_lstride;
    assign o_right_stride = r_rstride;

endmodule

>>> sv/bog_front.sv
module bog_front #(
    parameter int INDEX_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_restart,
    output logic                   o_full,
    input  bog_pkg::t_shape_status i_status,
    input  logic [INDEX_BITS-1:0]  i_total_m1,
    output logic                   o_cmd_empty,
    input  logic                   i_cmd_pop,
    output bog_pkg::t_cmd_ctl      o_cmd_ctl,
    output logic [INDEX_BITS-1:0]  o_cmd_index
);
    import bog_pkg::*;

    localparam int CMD_W = $bits(t_cmd_ctl) + INDEX_BITS;

    logic [INDEX_BITS-1:0] r_count;
    logic                  r_finished;
    logic [INDEX_BITS-1:0] n_count;
    logic                  n_finished;

    logic                  w_accept;
    logic                  w_q_full;
    t_cmd_ctl              w_ctl;
    logic [INDEX_BITS-1:0] w_index;
    logic [INDEX_BITS-1:0] w_inc;
    logic [CMD_W-1:0]      w_q_out;

    assign o_full   = w_q_full || i_status.busy;
    assign w_accept = i_push && !o_full;
    assign w_inc    = r_count + 1'b1;

    // Classify the word and track the element count
    always_comb begin
        n_count    = r_count;
        n_finished = r_finished;
        w_index    = '0;
        w_ctl.kind = CMD_EXHAUSTED;
        w_ctl.last = 1'b0;
        priority if (!i_status.ok) begin
            w_ctl.kind = CMD_ERROR;
            n_finished = 1'b1;
        end else if (i_restart) begin
            w_ctl.kind = CMD_RESTART;
            n_count    = '0;
            n_finished = (i_total_m1 == '0);
            w_ctl.last = n_finished;
        end else if (r_finished) begin
            w_ctl.kind = CMD_EXHAUSTED;
        end else begin
            w_ctl.kind = CMD_ADVANCE;
            n_count    = w_inc;
            n_finished = (w_inc >= i_total_m1);
            w_index    = w_inc;
            w_ctl.last = n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_finished <= 1'b1;
        end else if (w_accept) begin
            r_count    <= n_count;
            r_finished <= n_finished;
        end
    end

    // Queue classified words for the back end
    bog_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  ({w_ctl, w_index}),
        .o_full  (w_q_full),
        .i_pop   (i_cmd_pop),
        .o_empty (o_cmd_empty),
        .o_data  (w_q_out)
    );

    assign o_cmd_ctl   = t_cmd_ctl'(w_q_out[CMD_W-1:INDEX_BITS]);
    assign o_cmd_index = w_q_out[INDEX_BITS-1:0];

endmodule

>>> sv/bog_back.sv
module bog_back #(
    parameter int MAX_RANK   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    input  bog_pkg::t_cmd_ctl           i_cmd_ctl,
    input  logic [INDEX_BITS-1:0]       i_cmd_index,
    input  logic [bog_pkg::ORANK_W-1:0] i_orank,
    input  logic [DIM_BITS-1:0]         i_out_dims [MAX_RANK],
    input  logic                        i_left_unit [MAX_RANK],
    input  logic                        i_right_unit [MAX_RANK],
    input  logic [INDEX_BITS-1:0]       i_left_stride [MAX_RANK],
    input  logic [INDEX_BITS-1:0]       i_right_stride [MAX_RANK],
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [INDEX_BITS-1:0]       o_out_index,
    output logic [INDEX_BITS-1:0]       o_left_offset,
    output logic [INDEX_BITS-1:0]       o_right_offset,
    output bog_pkg::t_out_flags         o_flags
);
    import bog_pkg::*;

    localparam int AXIS_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int PW     = INDEX_BITS + DIM_BITS;
    localparam int OUT_W  = 3 * INDEX_BITS + $bits(t_out_flags);

    t_back_state           r_state, n_state;
    logic [AXIS_W-1:0]     r_axis, n_axis;
    logic [DIM_BITS-1:0]   r_coord [MAX_RANK];
    logic [DIM_BITS-1:0]   n_coord [MAX_RANK];
    logic [INDEX_BITS-1:0] r_index, n_index;
    logic                  r_last, n_last;
    logic [INDEX_BITS-1:0] r_lprod, n_lprod;
    logic [INDEX_BITS-1:0] r_rprod, n_rprod;
    logic [INDEX_BITS-1:0] r_lacc, n_lacc;
    logic [INDEX_BITS-1:0] r_racc, n_racc;

    logic [DIM_BITS-1:0]   w_odo [MAX_RANK];
    logic                  w_carry;
    logic [PW-1:0]         w_lmul;
    logic [PW-1:0]         w_rmul;
    logic                  w_out_push;
    logic [OUT_W-1:0]      w_out_data;
    logic                  w_out_full;
    logic [OUT_W-1:0]      w_out_q;
    t_out_flags            w_flags;

    // Step the output odometer over the active axes
    always_comb begin
        w_carry = 1'b1;
        w_odo   = r_coord;
        for (int a = 0; a < MAX_RANK; a++) begin
            if (w_carry && (ORANK_W'(a) < i_orank)) begin
                if (((DIM_BITS + 1)'(r_coord[a]) + 1'b1) < (DIM_BITS + 1)'(i_out_dims[a])) begin
                    w_odo[a] = DIM_BITS'(r_coord[a] + 1'b1);
                    w_carry  = 1'b0;
                end else begin
                    w_odo[a] = '0;
                end
            end
        end
    end

    // One coordinate-by-stride product per source and axis
    assign w_lmul = PW'(r_coord[r_axis]) * PW'(i_left_stride[r_axis]);
    assign w_rmul = PW'(r_coord[r_axis]) * PW'(i_right_stride[r_axis]);

    // Sequencer: take a word, walk the axes for an element word, emit the result
    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_coord    = r_coord;
        n_index    = r_index;
        n_last     = r_last;
        n_lprod    = r_lprod;
        n_rprod    = r_rprod;
        n_lacc     = r_lacc;
        n_racc     = r_racc;
        o_cmd_pop  = 1'b0;
        w_out_push = 1'b0;
        w_flags    = '0;
        w_out_data = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && !w_out_full) begin
                    o_cmd_pop = 1'b1;
                    n_axis    = '0;
                    n_lprod   = '0;
                    n_rprod   = '0;
                    n_lacc    = '0;
                    n_racc    = '0;
                    n_index   = i_cmd_index;
                    n_last    = i_cmd_ctl.last;
                    unique case (i_cmd_ctl.kind)
                        CMD_ERROR: begin
                            w_flags.exhausted   = 1'b1;
                            w_flags.shape_error = 1'b1;
                            w_out_push          = 1'b1;
                            w_out_data          = {{(3 * INDEX_BITS){1'b0}}, w_flags};
                        end
                        CMD_EXHAUSTED: begin
                            w_flags.exhausted = 1'b1;
                            w_out_push        = 1'b1;
                            w_out_data        = {{(3 * INDEX_BITS){1'b0}}, w_flags};
                        end
                        CMD_RESTART: begin
                            for (int a = 0; a < MAX_RANK; a++) begin
                                n_coord[a] = '0;
                            end
                            n_state = BK_MUL;
                        end
                        CMD_ADVANCE: begin
                            n_coord = w_odo;
                            n_state = BK_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            BK_MUL: begin
                n_lprod = i_left_unit[r_axis]  ? '0 : w_lmul[INDEX_BITS-1:0];
                n_rprod = i_right_unit[r_axis] ? '0 : w_rmul[INDEX_BITS-1:0];
                n_lacc  = r_lacc + r_lprod;
                n_racc  = r_racc + r_rprod;
                if (r_axis == AXIS_W'(MAX_RANK - 1)) begin
                    n_state = BK_SUM;
                end else begin
                    n_axis = r_axis + 1'b1;
                end
            end
            BK_SUM: begin
                w_flags.last = r_last;
                w_out_push   = 1'b1;
                w_out_data   = {r_index, r_lacc + r_lprod, r_racc + r_rprod, w_flags};
                n_state      = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_axis  <= '0;
            for (int a = 0; a < MAX_RANK; a++) begin
                r_coord[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_coord <= n_coord;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_index <= n_index;
        r_last  <= n_last;
        r_lprod <= n_lprod;
        r_rprod <= n_rprod;
        r_lacc  <= n_lacc;
        r_racc  <= n_racc;
    end

    // Hold finished results until taken
    bog_fifo #(
        .WIDTH (OUT_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_data),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (w_out_q)
    );

    assign o_out_index    = w_out_q[OUT_W-1 -: INDEX_BITS];
    assign o_left_offset  = w_out_q[OUT_W-1-INDEX_BITS -: INDEX_BITS];
    assign o_right_offset = w_out_q[OUT_W-1-2*INDEX_BITS -: INDEX_BITS];
    assign o_flags        = t_out_flags'(w_out_q[$bits(t_out_flags)-1:0]);

endmodule

>>> sv/broadcast_offset_generator.sv
// An element word passes from the command queue through the back end's MUL state for
// each axis and its SUM state into the result queue; an exhausted or shape-error word
// goes from the command queue straight into the result queue. The back-end sequencer
// walks the axes through one shared multiplier pair and takes no new word until done.
// Reset and every register write start a shape check over all MAX_RANK axes with full
// held high; after reset the stream is finished and needs a restart word.
module broadcast_offset_generator #(
    parameter int MAX_RANK   = bog_pkg::MAX_RANK_DEF,
    parameter int DIM_BITS   = bog_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = bog_pkg::INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bog_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bog_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bog_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_restart,
    output logic                           empty,
    input  logic                           pop,
    output logic [INDEX_BITS-1:0]          o_out_index,
    output logic [INDEX_BITS-1:0]          o_left_offset,
    output logic [INDEX_BITS-1:0]          o_right_offset,
    output logic                           o_last,
    output logic                           o_exhausted,
    output logic                           o_shape_error
);
    import bog_pkg::*;

    t_shape_status         w_status;
    logic [INDEX_BITS-1:0] w_total_m1;
    logic [ORANK_W-1:0]    w_orank;
    logic [DIM_BITS-1:0]   w_out_dims [MAX_RANK];
    logic                  w_left_unit [MAX_RANK];
    logic                  w_right_unit [MAX_RANK];
    logic [INDEX_BITS-1:0] w_left_stride [MAX_RANK];
    logic [INDEX_BITS-1:0] w_right_stride [MAX_RANK];
    logic                  w_cmd_empty;
    logic                  w_cmd_pop;
    t_cmd_ctl              w_cmd_ctl;
    logic [INDEX_BITS-1:0] w_cmd_index;
    t_out_flags            w_flags;

    // Registers and shape check
    bog_cfg #(
        .MAX_RANK   (MAX_RANK),
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_pready       (pready),
        .o_status       (w_status),
        .o_total_m1     (w_total_m1),
        .o_orank        (w_orank),
        .o_out_dims     (w_out_dims),
        .o_left_unit    (w_left_unit),
        .o_right_unit   (w_right_unit),
        .o_left_stride  (w_left_stride),
        .o_right_stride (w_right_stride)
    );

    // Accept and classify words
    bog_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_restart   (i_restart),
        .o_full      (full),
        .i_status    (w_status),
        .i_total_m1  (w_total_m1),
        .o_cmd_empty (w_cmd_empty),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd_ctl   (w_cmd_ctl),
        .o_cmd_index (w_cmd_index)
    );

    // Walk coordinates and form offsets
    bog_back #(
        .MAX_RANK   (MAX_RANK),
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (w_cmd_empty),
        .o_cmd_pop      (w_cmd_pop),
        .i_cmd_ctl      (w_cmd_ctl),
        .i_cmd_index    (w_cmd_index),
        .i_orank        (w_orank),
        .i_out_dims     (w_out_dims),
        .i_left_unit    (w_left_unit),
        .i_right_unit   (w_right_unit),
        .i_left_stride  (w_left_stride),
        .i_right_stride (w_right_stride),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_out_index    (o_out_index),
        .o_left_offset  (o_left_offset),
        .o_right_offset (o_right_offset),
        .o_flags        (w_flags)
    );

    assign o_last        = w_flags.last;
    assign o_exhausted   = w_flags.exhausted;
    assign o_shape_error = w_flags.shape_error;

endmodule

>>> tb/tb_broadcast_offset_generator.sv
`timescale 1ns / 100ps

module tb_broadcast_offset_generator;
    import bog_pkg::*;

    localparam int AXES    = MAX_RANK_DEF;
    localparam int DIM_W   = DIM_BITS_DEF;
    localparam int IDX_W   = INDEX_BITS_DEF;
    localparam longint unsigned IDX_MAX = (64'd1 << IDX_W) - 64'd1;
    localparam int SETTLE_CYCLES = 2 * (AXES + 2);
    localparam int STALL_CYCLES  = 100;
    localparam int RANDOM_WORDS  = 500;
    localparam int ADVANCE_CAP   = 40;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [IDX_W-1:0] left_offset;
        logic [IDX_W-1:0] right_offset;
        logic             last;
        logic             exhausted;
        logic             shape_error;
    } elem_word_t;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push      = 1'b0;
    logic                  full;
    logic                  i_restart = 1'b0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [IDX_W-1:0]      o_out_index;
    logic [IDX_W-1:0]      o_left_offset;
    logic [IDX_W-1:0]      o_right_offset;
    logic                  o_last;
    logic                  o_exhausted;
    logic                  o_shape_error;

    broadcast_offset_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_restart      (i_restart),
        .empty          (empty),
        .pop            (pop),
        .o_out_index    (o_out_index),
        .o_left_offset  (o_left_offset),
        .o_right_offset (o_right_offset),
        .o_last         (o_last),
        .o_exhausted    (o_exhausted),
        .o_shape_error  (o_shape_error)
    );

    // Register copies as the block should hold them
    logic [CFG_DATA_W-1:0] cfg_left_dims  = DIMS_RESET;
    logic [CFG_DATA_W-1:0] cfg_right_dims = DIMS_RESET;
    logic [RANK_W-1:0]     cfg_left_rank  = RANK_RESET;
    logic [RANK_W-1:0]     cfg_right_rank = RANK_RESET;

    // Odometer state of the address walk
    logic [DIM_W-1:0] odo_coord [AXES] = '{default: '0};
    logic [IDX_W-1:0] odo_count = '0;
    logic             odo_done  = 1'b1;

    // Resolved shape, refreshed on every step
    longint unsigned shp_l [AXES];
    longint unsigned shp_r [AXES];
    longint unsigned shp_o [AXES];
    int              shp_rank;
    longint unsigned shp_total;

    elem_word_t expected_words [$];
    bit         restart_words [$];

    int  words_sent   = 0;
    int  words_in     = 0;
    int  words_out    = 0;
    int  faults       = 0;
    int  lasts_seen   = 0;
    int  errors_seen  = 0;
    int  shape_phases = 0;
    bit  tx_burst     = 1'b0;
    bit  rx_burst     = 1'b0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    int  rx_seen      = 0;
    int  rx_stall_reqs = 0;
    int  rx_stall_seen = 0;
    int  rx_stall_left = 0;

    // Align both shapes, broadcast per axis and bound the element count
    function automatic bit resolve_shape();
        int              lr;
        int              rr;
        bit              ok;
        longint unsigned prod;
        lr = (cfg_left_rank > AXES) ? AXES : int'(cfg_left_rank);
        rr = (cfg_right_rank > AXES) ? AXES : int'(cfg_right_rank);
        shp_rank = (lr > rr) ? lr : rr;
        ok = 1'b1;
        prod = 64'd1;
        for (int a = 0; a < AXES; a++) begin
            shp_l[a] = (a < lr) ? 64'(cfg_left_dims[a*DIM_W +: DIM_W]) : 64'd1;
            shp_r[a] = (a < rr) ? 64'(cfg_right_dims[a*DIM_W +: DIM_W]) : 64'd1;
            shp_o[a] = (shp_l[a] > shp_r[a]) ? shp_l[a] : shp_r[a];
            if (shp_l[a] == 64'd0 || shp_r[a] == 64'd0) begin
                ok = 1'b0;
            end else if (shp_l[a] != shp_r[a] && shp_l[a] != 64'd1 && shp_r[a] != 64'd1) begin
                ok = 1'b0;
            end
            if (ok && a < shp_rank) begin
                if (prod > IDX_MAX / shp_o[a]) ok = 1'b0;
                else prod = prod * shp_o[a];
            end
        end
        shp_total = prod;
        return ok;
    endfunction

    // Offset into one source: broadcast axes add nothing
    function automatic logic [IDX_W-1:0] src_offset(input bit use_right);
        longint unsigned off;
        longint unsigned stride;
        longint unsigned d;
        off = 64'd0;
        stride = 64'd1;
        for (int a = 0; a < AXES; a++) begin
            d = use_right ? shp_r[a] : shp_l[a];
            if (d != 64'd1) off = off + 64'(odo_coord[a]) * stride;
            stride = stride * d;
        end
        return off[IDX_W-1:0];
    endfunction

    // Advance or restart the odometer and form the expected word
    function automatic elem_word_t step_odometer(input logic restart);
        elem_word_t      w;
        bit              carry;
        longint unsigned nxt;
        w = '0;
        if (!resolve_shape()) begin
            odo_done = 1'b1;
            w.exhausted = 1'b1;
            w.shape_error = 1'b1;
            return w;
        end
        if (restart) begin
            for (int a = 0; a < AXES; a++) odo_coord[a] = '0;
            odo_count = '0;
        end else begin
            if (odo_done) begin
                w.exhausted = 1'b1;
                return w;
            end
            carry = 1'b1;
            for (int a = 0; a < AXES; a++) begin
                if (carry && a < shp_rank) begin
                    nxt = 64'(odo_coord[a]) + 64'd1;
                    if (nxt < shp_o[a]) begin
                        odo_coord[a] = nxt[DIM_W-1:0];
                        carry = 1'b0;
                    end else begin
                        odo_coord[a] = '0;
                    end
                end
            end
            odo_count = odo_count + 1'b1;
        end
        odo_done = (64'(odo_count) >= shp_total - 64'd1);
        w.out_index = odo_count;
        w.left_offset = src_offset(1'b0);
        w.right_offset = src_offset(1'b1);
        w.last = odo_done;
        return w;
    endfunction

    function automatic int pick_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Drive queued words with their restart flags; hold each until taken, then pause as drawn
    always @(negedge i_clk) begin
        if (i_rst_n && !(push && words_in != words_sent)) begin
            if (push) tx_gap = pick_gap(tx_burst);
            if (tx_gap != 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (restart_words.size() == 0) begin
                push <= 1'b0;
            end else begin
                i_restart <= restart_words.pop_front();
                push <= 1'b1;
                words_sent++;
            end
        end
    end

    // Pace the result side, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (words_out != rx_seen) begin
                rx_seen = words_out;
                rx_gap = pick_gap(rx_burst);
            end
            if (rx_stall_reqs != rx_stall_seen) begin
                rx_stall_seen = rx_stall_reqs;
                rx_stall_left = STALL_CYCLES;
            end
            if (rx_stall_left != 0) begin
                rx_stall_left--;
                pop <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Check taken result words, then predict for a taken input word
    always @(posedge i_clk) begin : word_monitor
        elem_word_t got;
        elem_word_t want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                got = {o_out_index, o_left_offset, o_right_offset,
                       o_last, o_exhausted, o_shape_error};
                words_out++;
                if (got.last) lasts_seen++;
                if (got.shape_error) errors_seen++;
                if (expected_words.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected result word %0d: idx %0d left %0d right %0d",
                                 words_out, got.out_index, got.left_offset, got.right_offset);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        faults++;
                        if (faults <= 10) begin
                            $display("result word %0d mismatch", words_out);
                            $display("  expected idx %0d left %0d right %0d last %b exh %b err %b",
                                     want.out_index, want.left_offset, want.right_offset,
                                     want.last, want.exhausted, want.shape_error);
                            $display("  got      idx %0d left %0d right %0d last %b exh %b err %b",
                                     got.out_index, got.left_offset, got.right_offset,
                                     got.last, got.exhausted, got.shape_error);
                        end
                    end
                end
            end
            if (push && !full) begin
                expected_words.push_back(step_odometer(i_restart));
                words_in++;
            end
        end
    end

    // Wait until every word is through, then let the block go quiet
    task automatic settle();
        while (restart_words.size() != 0 || words_in != words_sent
               || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_LEFT_DIMS:  cfg_left_dims = value;
            REG_RIGHT_DIMS: cfg_right_dims = value;
            REG_LEFT_RANK:  cfg_left_rank = value[RANK_W-1:0];
            REG_RIGHT_RANK: cfg_right_rank = value[RANK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_shape(input logic [63:0] ld, input logic [63:0] rd,
                             input logic [RANK_W-1:0] lr, input logic [RANK_W-1:0] rr);
        settle();
        write_reg(REG_LEFT_DIMS, ld);
        write_reg(REG_RIGHT_DIMS, rd);
        write_reg(REG_LEFT_RANK, 64'(lr));
        write_reg(REG_RIGHT_RANK, 64'(rr));
        shape_phases++;
    endtask

    task automatic send_words(input bit with_restart, input int advances);
        if (with_restart) restart_words.push_back(1'b1);
        repeat (advances) restart_words.push_back(1'b0);
    endtask

    // Draw a shape pair: mostly broadcastable, some wide, broken or wild
    task automatic roll_shape();
        logic [63:0]       ld;
        logic [63:0]       rd;
        logic [RANK_W-1:0] lr;
        logic [RANK_W-1:0] rr;
        int                kind;
        int                d;
        int                ax;
        ld = {$urandom, $urandom};
        rd = {$urandom, $urandom};
        lr = ($urandom_range(0, 9) == 0) ? RANK_W'($urandom_range(5, 7))
                                         : RANK_W'($urandom_range(0, 4));
        rr = ($urandom_range(0, 9) == 0) ? RANK_W'($urandom_range(5, 7))
                                         : RANK_W'($urandom_range(0, 4));
        kind = $urandom_range(0, 9);
        if (kind != 9) begin
            for (ax = 0; ax < AXES; ax++) begin
                d = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 3);
                if (ax < lr)
                    ld[ax*DIM_W +: DIM_W] = ($urandom_range(0, 1) != 0) ? DIM_W'(d) : DIM_W'(1);
                if (ax < rr)
                    rd[ax*DIM_W +: DIM_W] = ($urandom_range(0, 1) != 0) ? DIM_W'(d) : DIM_W'(1);
            end
        end
        if (kind == 7) begin
            // one wide axis on the left, broadcast on the right
            ax = $urandom_range(0, 1);
            ld[ax*DIM_W +: DIM_W] = DIM_W'($urandom_range(1000, 65535));
            rd[ax*DIM_W +: DIM_W] = DIM_W'(1);
            if (lr <= ax) lr = RANK_W'(ax + 1);
        end else if (kind == 8) begin
            // clash or zero within the ranks
            ax = $urandom_range(0, AXES - 1);
            lr = RANK_W'(AXES);
            rr = RANK_W'(AXES);
            if ($urandom_range(0, 1) != 0) begin
                ld[ax*DIM_W +: DIM_W] = '0;
            end else begin
                ld[ax*DIM_W +: DIM_W] = DIM_W'(2);
                rd[ax*DIM_W +: DIM_W] = DIM_W'(3);
            end
        end
        set_shape(ld, rd, lr, rr);
    endtask

    // Stimulus
    initial begin : stimulus
        int random_words;
        int phase;
        int n;
        bit first;
        random_words = 0;
        phase = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle after reset until restarted, then a one-element stream
        send_words(1'b0, 1);
        send_words(1'b1, 1);
        // 3x2 left against a 3-long right, junk above the right rank
        set_shape({16'd1, 16'd1, 16'd2, 16'd3}, {16'hBEEF, 16'h0, 16'hFFFF, 16'd3},
                  3'd2, 3'd1);
        send_words(1'b1, 6);
        // both scalars
        set_shape(64'h0, 64'h0, 3'd0, 3'd0);
        send_words(1'b1, 1);
        // clashing dimensions
        set_shape({16'd1, 16'd1, 16'd1, 16'd3}, {16'd1, 16'd1, 16'd1, 16'd4}, 3'd1, 3'd1);
        send_words(1'b0, 1);
        // zero dimension
        set_shape({16'd1, 16'd1, 16'd1, 16'd0}, DIMS_RESET, 3'd1, 3'd1);
        send_words(1'b1, 0);
        // oversized rank saturates
        set_shape({16'd2, 16'd1, 16'd1, 16'd2}, {16'd7, 16'd7, 16'd7, 16'd7}, 3'd7, 3'd0);
        send_words(1'b1, 2);
        // element count beyond the index range
        set_shape({4{16'hFFFF}}, {4{16'hFFFF}}, 3'd4, 3'd4);
        send_words(1'b1, 0);
        // largest dimensions that still fit
        set_shape({16'd1, 16'd1, 16'hFFFF, 16'hFFFF}, {16'd1, 16'd1, 16'd1, 16'hFFFF},
                  3'd2, 3'd1);
        send_words(1'b1, 1);
        // shrink the shape under a running stream
        set_shape({16'd1, 16'd1, 16'd3, 16'd4}, 64'h0, 3'd2, 3'd0);
        send_words(1'b1, 6);
        set_shape({16'd1, 16'd1, 16'd3, 16'd2}, 64'h0, 3'd2, 3'd0);
        send_words(1'b0, 2);

        // random shapes and streams
        while (random_words < RANDOM_WORDS) begin
            phase++;
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                // hold off the receiver while the sender keeps pushing
                set_shape({16'd1, 16'd1, 16'd4, 16'd5}, {16'd1, 16'd1, 16'd1, 16'd5},
                          3'd2, 3'd1);
                tx_burst = 1'b1;
                rx_stall_reqs++;
                send_words(1'b1, 24);
                random_words += 25;
            end else if (phase == 6) begin
                // sender pauses mid-stream until all results are back
                set_shape({16'd1, 16'd3, 16'd1, 16'd3}, {16'd1, 16'd1, 16'd3, 16'd3},
                          3'd3, 3'd2);
                send_words(1'b1, 10);
                settle();
                send_words(1'b0, 10);
                random_words += 21;
            end else begin
                roll_shape();
                if (resolve_shape())
                    n = (shp_total + 64'd2 > 64'(ADVANCE_CAP)) ? ADVANCE_CAP
                        : int'(shp_total) + $urandom_range(0, 2);
                else
                    n = $urandom_range(1, 3);
                first = ($urandom_range(0, 3) != 0);
                restart_words.push_back(first);
                for (int i = 0; i < n; i++)
                    restart_words.push_back($urandom_range(0, 24) == 0);
                random_words += n + 1;
            end
        end

        settle();
        $display("%0d words in, %0d results checked over %0d shape settings",
                 words_in, words_out, shape_phases);
        $display("%0d last markers, %0d shape errors, %0d faults",
                 lasts_seen, errors_seen, faults);
        if (faults == 0 && expected_words.size() == 0) begin
            $display("tb_broadcast_offset_generator passed");
        end else begin
            $display("tb_broadcast_offset_generator failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("tb_broadcast_offset_generator failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/bog_pkg.sv
sv/bog_fifo.sv
sv/bog_cfg.sv
sv/bog_front.sv
sv/bog_back.sv
sv/broadcast_offset_generator.sv
tb/tb_broadcast_offset_generator.sv
